// ===== design/mlp_forward_pass_unit_defines.svh =====
// assertion macros for the mlp forward pass unit
// no dependencies
`ifndef MLP_FORWARD_PASS_UNIT_DEFINES_SVH
`define MLP_FORWARD_PASS_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MLP_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define MLP_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== design/mlp_pkg.sv =====
// shared types, constants and sigmoid helper for the mlp forward pass unit
// no dependencies
`default_nettype none
package mlp_pkg;
	localparam int MAX_LAYERS = 4;
	localparam int MAX_WIDTH = 16;

	typedef enum logic [2:0] {
		CFG_LAYER_COUNT = 3'd0,
		CFG_WIDTH_0 = 3'd1,
		CFG_WIDTH_1 = 3'd2,
		CFG_WIDTH_2 = 3'd3,
		CFG_WIDTH_3 = 3'd4
	} cfg_idx_t;

	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_INPUT = 1'b1;

	typedef struct packed {
		logic kind;
		logic [1:0] layer;
		logic [3:0] neuron;
		logic [3:0] position;
		logic signed [15:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0] out_index;
		logic [12:0] out_value;
		logic last;
	} result_t;

	// sigmoid table entry k is round(4096*sigmoid(k/2))
	function automatic logic [11:0] sig_tab(input logic [4:0] k);
		logic [11:0] r;
		begin
			case (k)
				5'd0: r = 12'd2048;
				5'd1: r = 12'd2550;
				5'd2: r = 12'd2994;
				5'd3: r = 12'd3349;
				5'd4: r = 12'd3608;
				5'd5: r = 12'd3785;
				5'd6: r = 12'd3902;
				5'd7: r = 12'd3976;
				5'd8: r = 12'd4022;
				5'd9: r = 12'd4051;
				5'd10: r = 12'd4069;
				5'd11: r = 12'd4079;
				5'd12: r = 12'd4086;
				5'd13: r = 12'd4090;
				5'd14: r = 12'd4092;
				5'd15: r = 12'd4094;
				default: r = 12'd4095;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// ===== design/mlp_forward_pass_unit.sv =====
// top level of the mlp forward pass unit: registers, front and back ends
// depends on mlp_pkg, mlp_front, mlp_back and the defines header
//
// usage: drive req with start; a request is taken when start is high and busy
// low. weight requests store one q3.12 weight; input requests store one input
// element, and the element at position width_0-1 launches a forward pass.
// busy is high from that launch until the last result has been strobed.
// results come on result with done high for one cycle each, final-layer
// neurons in order, last set on the final one; nothing can stall them. a
// pass runs the single multiply-accumulate loop for each neuron of each layer
// after the inputs, then emits. cfg_we/cfg_idx/cfg_data write the registers;
// the user must write them while busy is low; the block does not enforce it.
// reset clears control state and restores layer_count 2 and widths 16; the
// weight and activation memories hold nothing defined until written.
`default_nettype none
`include "mlp_forward_pass_unit_defines.svh"
module mlp_forward_pass_unit #(
	parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS,
	parameter int MAX_WIDTH = mlp_pkg::MAX_WIDTH,
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int LW = $clog2(MAX_LAYERS),
	localparam int WAW = $clog2((MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mlp_pkg::req_t req,
	output logic done,
	output mlp_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [4:0] cfg_data
);
	logic [2:0] lc_q;
	logic [4:0] w_q [4];
	logic [LW:0] nl;
	logic [IW:0] wid [MAX_LAYERS];
	logic accept, in_we, pass_valid, pass_take;
	logic [IW-1:0] in_pos;
	logic signed [15:0] in_val, wrd_data;
	logic [WAW-1:0] wrd_addr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= 3'd2;
			for (int i = 0; i < 4; i++) w_q[i] <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_idx)
				mlp_pkg::CFG_LAYER_COUNT: lc_q <= cfg_data[2:0];
				mlp_pkg::CFG_WIDTH_0: w_q[0] <= cfg_data;
				mlp_pkg::CFG_WIDTH_1: w_q[1] <= cfg_data;
				mlp_pkg::CFG_WIDTH_2: w_q[2] <= cfg_data;
				mlp_pkg::CFG_WIDTH_3: w_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped layer count and widths
	always_comb begin
		if (lc_q < 3'd2) nl = (LW + 1)'(2);
		else if (32'(lc_q) > MAX_LAYERS) nl = (LW + 1)'(MAX_LAYERS);
		else if (lc_q > 3'd4) nl = (LW + 1)'(4);
		else nl = (LW + 1)'(lc_q);
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (i >= 4 || w_q[i % 4] == 5'd0) wid[i] = (IW + 1)'(1);
			else if (32'(w_q[i % 4]) > MAX_WIDTH) wid[i] = (IW + 1)'(MAX_WIDTH);
			else wid[i] = (IW + 1)'(w_q[i % 4]);
		end
	end

	assign accept = start && !busy;

	mlp_front #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .req(req), .w0(wid[0]),
		.wrd_addr(wrd_addr), .wrd_data(wrd_data), .in_we(in_we), .in_pos(in_pos),
		.in_val(in_val), .pass_valid(pass_valid), .pass_take(pass_take)
	);

	mlp_back #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .nl(nl), .wid(wid), .in_we(in_we), .in_pos(in_pos),
		.in_val(in_val), .pass_valid(pass_valid), .pass_take(pass_take),
		.wrd_addr(wrd_addr), .wrd_data(wrd_data), .busy(busy), .done(done), .result(result)
	);

	// checks
	`MLP_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done || $past(done, 2), "done pattern")
	`MLP_ASSERT_IMP(a_done_busy, clk, arst_n, done && !result.last, busy, "busy dropped mid pass")
	`MLP_ASSERT_NEXT(a_last_idle, clk, arst_n, done && result.last, !done, "result after last")
endmodule
`default_nettype wire

// ===== design/mlp_front.sv =====
// front end: takes requests, writes weights, decides which input starts a pass
// depends on mlp_pkg
`default_nettype none
module mlp_front #(
	parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS,
	parameter int MAX_WIDTH = mlp_pkg::MAX_WIDTH,
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int LW = $clog2(MAX_LAYERS),
	localparam int WD = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH,
	localparam int WAW = $clog2(WD)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire mlp_pkg::req_t req,
	input wire logic [IW:0] w0,
	// weight memory read port for the back end
	input wire logic [WAW-1:0] wrd_addr,
	output logic signed [15:0] wrd_data,
	// input element write towards the back end
	output logic in_we,
	output logic [IW-1:0] in_pos,
	output logic signed [15:0] in_val,
	// queued pass request
	output logic pass_valid,
	input wire logic pass_take
);
	logic signed [15:0] wmem [WD];
	logic pass_q;
	logic [LW:0] lay_ext;
	logic w_ok;
	logic [WAW-1:0] w_addr;

	// weight address and range check
	always_comb begin
		lay_ext = (LW + 1)'(req.layer);
		w_ok = (lay_ext >= (LW + 1)'(1)) && (lay_ext < (LW + 1)'(MAX_LAYERS))
			&& (32'(req.neuron) < 32'(MAX_WIDTH)) && (32'(req.position) < 32'(MAX_WIDTH));
		w_addr = WAW'((32'(lay_ext) - 32'd1) * 32'(MAX_WIDTH * MAX_WIDTH)
			+ 32'(req.neuron) * 32'(MAX_WIDTH) + 32'(req.position));
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (accept && req.kind == mlp_pkg::KIND_WEIGHT && w_ok) begin
			wmem[w_addr] <= req.value;
		end
		wrd_data <= wmem[wrd_addr];
	end

	// input element forwarding
	always_comb begin
		in_we = accept && req.kind == mlp_pkg::KIND_INPUT
			&& (32'(req.position) < 32'(MAX_WIDTH));
		in_pos = IW'(req.position);
		in_val = req.value;
	end

	// one-deep pass queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (in_we && (IW + 1)'(req.position) == w0 - (IW + 1)'(1)) begin
			pass_q <= 1'b1;
		end else if (pass_take) begin
			pass_q <= 1'b0;
		end
	end
	assign pass_valid = pass_q;
endmodule
`default_nettype wire

// ===== design/mlp_back.sv =====
// back end: sequences the multiply-accumulate, sigmoid and result emission
// depends on mlp_pkg
`default_nettype none
module mlp_back #(
	parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS,
	parameter int MAX_WIDTH = mlp_pkg::MAX_WIDTH,
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int LW = $clog2(MAX_LAYERS),
	localparam int WD = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH,
	localparam int WAW = $clog2(WD),
	localparam int AD = MAX_LAYERS * MAX_WIDTH,
	localparam int AAW = $clog2(AD)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [LW:0] nl,
	input wire logic [IW:0] wid [MAX_LAYERS],
	input wire logic in_we,
	input wire logic [IW-1:0] in_pos,
	input wire logic signed [15:0] in_val,
	input wire logic pass_valid,
	output logic pass_take,
	output logic [WAW-1:0] wrd_addr,
	input wire logic signed [15:0] wrd_data,
	output logic busy,
	output logic done,
	output mlp_pkg::result_t result
);
	typedef enum logic [2:0] {IDLE, MAC, DRAIN, SAT, SIG, WB, EMIT} st_t;
	st_t st_q;
	logic signed [15:0] amem [AD];
	logic signed [15:0] ard_q;
	logic [LW-1:0] l_q;
	logic [IW-1:0] j_q, k_q;
	logic [IW:0] wl, wp;
	logic [1:0] pipe_q;
	logic signed [31:0] prod_q;
	logic signed [40:0] acc_q;
	logic signed [15:0] x_q;
	logic [12:0] y_q;
	logic signed [40:0] q;
	logic signed [15:0] sat;
	logic [14:0] ax;
	logic [3:0] seg;
	logic [10:0] frac;
	logic [11:0] t0, t1;
	logic [23:0] interp;
	logic [12:0] pos_v;
	logic last_k;
	logic [AAW-1:0] ard_addr;

	assign wl = wid[l_q];
	assign wp = wid[l_q - LW'(1)];
	assign last_k = (IW + 1)'(k_q) == wp - (IW + 1)'(1);
	assign wrd_addr = WAW'((32'(l_q) - 32'd1) * 32'(MAX_WIDTH * MAX_WIDTH)
		+ 32'(j_q) * 32'(MAX_WIDTH) + 32'(k_q));
	assign ard_addr = (st_q == EMIT) ? AAW'(32'(nl - (LW + 1)'(1)) * 32'(MAX_WIDTH) + 32'(j_q))
		: AAW'(32'(l_q - LW'(1)) * 32'(MAX_WIDTH) + 32'(k_q));

	// activation memory, inputs in row zero
	always_ff @(posedge clk) begin
		if (in_we) begin
			amem[AAW'(in_pos)] <= in_val;
		end else if (st_q == WB) begin
			amem[AAW'(32'(l_q) * 32'(MAX_WIDTH) + 32'(j_q))] <= $signed(16'(y_q));
		end
		ard_q <= amem[ard_addr];
	end

	// floor shift, saturation and sigmoid interpolation
	always_comb begin
		q = acc_q >>> 12;
		if (q > 41'sd32767) begin
			sat = 16'sd32767;
		end else if (q < -41'sd32768) begin
			sat = -16'sd32768;
		end else begin
			sat = q[15:0];
		end
		ax = x_q[15] ? 15'(-{x_q[15], x_q}) : x_q[14:0];
		seg = ax[14:11];
		frac = ax[10:0];
		t0 = mlp_pkg::sig_tab({1'b0, seg});
		t1 = mlp_pkg::sig_tab({1'b0, seg} + 5'd1);
		interp = (24'(t1 - t0) * 24'(frac) + 24'd1024) >> 11;
		pos_v = (x_q == -16'sd32768) ? 13'd4095 : 13'(t0) + 13'(interp);
	end

	// sequencer: mac loop per neuron, then saturation, sigmoid and writeback, then result emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			l_q <= LW'(1);
			j_q <= '0;
			k_q <= '0;
			pipe_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				IDLE: begin
					if (pass_valid && !in_we) begin
						st_q <= MAC;
						l_q <= LW'(1);
						j_q <= '0;
						k_q <= '0;
						acc_q <= '0;
						pipe_q <= '0;
					end
				end
				MAC: begin
					pipe_q <= {pipe_q[0], 1'b1};
					if (pipe_q[1]) acc_q <= acc_q + 41'(prod_q);
					if (last_k) st_q <= DRAIN; else k_q <= k_q + IW'(1);
				end
				DRAIN: begin
					pipe_q <= {pipe_q[0], 1'b0};
					if (pipe_q[1]) acc_q <= acc_q + 41'(prod_q);
					if (pipe_q == 2'b10) st_q <= SAT;
				end
				SAT: begin
					x_q <= sat;
					st_q <= SIG;
				end
				SIG: begin
					y_q <= x_q[15] ? 13'd4096 - pos_v : pos_v;
					st_q <= WB;
				end
				WB: begin
					k_q <= '0;
					acc_q <= '0;
					pipe_q <= '0;
					if ((IW + 1)'(j_q) != wl - (IW + 1)'(1)) begin
						j_q <= j_q + IW'(1);
						st_q <= MAC;
					end else if ((LW + 1)'(l_q) != nl - (LW + 1)'(1)) begin
						j_q <= '0;
						l_q <= l_q + LW'(1);
						st_q <= MAC;
					end else begin
						j_q <= '0;
						pipe_q <= 2'b01;
						st_q <= EMIT;
					end
				end
				EMIT: begin
					// the read address is issued while pipe_q[0] is set, before the strobe
					if (pipe_q[0]) begin
						pipe_q <= 2'b00;
					end else begin
						done <= 1'b1;
						result.out_index <= 4'(j_q);
						result.out_value <= 13'(ard_q);
						result.last <= (IW + 1)'(j_q) == wl - (IW + 1)'(1);
						if ((IW + 1)'(j_q) == wl - (IW + 1)'(1)) begin
							st_q <= IDLE;
						end else begin
							j_q <= j_q + IW'(1);
							pipe_q <= 2'b01;
						end
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	// product register after both memory reads
	always_ff @(posedge clk) begin
		prod_q <= 32'(wrd_data) * 32'(ard_q);
	end

	assign pass_take = (st_q == IDLE) && pass_valid && !in_we;
	assign busy = (st_q != IDLE) || pass_valid;
endmodule
`default_nettype wire
